/* rtl/mm4_pkg.sv */
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// Depends on nothing; every other RTL file refers to it by scoped names, and the testbench imports it.
`default_nettype none

package mm4_pkg;

   localparam int MAT_DIM        = 4;
   localparam int ROW_W          = 2;
   localparam int FIELD_W        = 32;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int DEF_ELEM_WIDTH = 32;
   localparam int LANE_STAGES    = 3;

   typedef enum logic [1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_PRODUCT = 2'd2,
      ACT_UNUSED  = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]                action;
      logic [ROW_W-1:0]          row_index;
      logic signed [FIELD_W-1:0] elem0;
      logic signed [FIELD_W-1:0] elem1;
      logic signed [FIELD_W-1:0] elem2;
      logic signed [FIELD_W-1:0] elem3;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]          out_row;
      logic signed [FIELD_W-1:0] prod0;
      logic signed [FIELD_W-1:0] prod1;
      logic signed [FIELD_W-1:0] prod2;
      logic signed [FIELD_W-1:0] prod3;
      logic                      last_row;
   } rsp_type;

   // Row write control from the top level's request decode to the matrix store.
   typedef struct packed {
      logic             load_a;
      logic             load_b;
      logic [ROW_W-1:0] row;
   } wr_ctrl_type;

   // Tag that travels beside the lanes: which product row is in flight.
   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
   } tag_type;

endpackage

`default_nettype wire

/* rtl/mm4_store.sv */
// Register storage for the left (A) and right (B) 4x4 matrices, row-major.
// Depends on mm4_pkg for dimensions and the write control struct.
`default_nettype none

module mm4_store #(
   parameter int ELEM_WIDTH = mm4_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   input  wire mm4_pkg::wr_ctrl_type                               wr_ctrl,
   input  wire logic [mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0]        wr_elems,
   input  wire logic [mm4_pkg::ROW_W-1:0]                          rd_row,
   output logic [mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0]             a_row,
   output logic [mm4_pkg::MAT_DIM-1:0][mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] b_mat
);

   logic [mm4_pkg::MAT_DIM-1:0][mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] a_ff, a_in;
   logic [mm4_pkg::MAT_DIM-1:0][mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] b_ff, b_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (wr_ctrl.load_a) begin
         a_in[wr_ctrl.row] = wr_elems;
      end
      if (wr_ctrl.load_b) begin
         b_in[wr_ctrl.row] = wr_elems;
      end
   end

   // Both matrices read as zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign a_row = a_ff[rd_row];
   assign b_mat = b_ff;

endmodule

`default_nettype wire

/* rtl/mm4_lane.sv */
// One dot-product lane: four signed multiplies, then a two-level registered adder tree.
// Depends on mm4_pkg for the matrix dimension.
`default_nettype none

module mm4_lane #(
   parameter int ELEM_WIDTH = mm4_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic                                        clock,
   input  wire logic [mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] a_row,
   input  wire logic [mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] b_col,
   output logic [2*ELEM_WIDTH+1:0]                          sum
);

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int NPAIR  = mm4_pkg::MAT_DIM / 2;

   logic [mm4_pkg::MAT_DIM-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [NPAIR-1:0][PAIR_W-1:0]            pair_ff, pair_in;
   logic [SUM_W-1:0]                        sum_ff, sum_in;

   always_comb begin
      for (int k = 0; k < mm4_pkg::MAT_DIM; k++) begin
         prod_in[k] = PROD_W'($signed(a_row[k]) * $signed(b_col[k]));
      end
      for (int p = 0; p < NPAIR; p++) begin
         pair_in[p] = PAIR_W'($signed(prod_ff[2*p])) + PAIR_W'($signed(prod_ff[2*p+1]));
      end
      sum_in = SUM_W'($signed(pair_ff[0])) + SUM_W'($signed(pair_ff[1]));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pair_ff <= pair_in;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

/* rtl/mm4_merge.sv */
// Merging stage: scales and saturates the four lane sums and registers one result row.
// Depends on mm4_pkg for the tag and result structs.
`default_nettype none

module mm4_merge #(
   parameter int FRAC_BITS  = mm4_pkg::DEF_FRAC_BITS,
   parameter int ELEM_WIDTH = mm4_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire mm4_pkg::tag_type                                 tag,
   input  wire logic [mm4_pkg::MAT_DIM-1:0][2*ELEM_WIDTH+1:0]    lane_sum,
   output logic                                                  rsp_valid,
   output mm4_pkg::rsp_type                                      rsp_data
);

   localparam int SUM_W = 2 * ELEM_WIDTH + 2;

   logic signed [SUM_W-1:0]                         shifted;
   logic [mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0]     clip;
   logic [mm4_pkg::MAT_DIM-1:0][mm4_pkg::FIELD_W-1:0] elem_out;
   logic                                            rsp_valid_ff, rsp_valid_in;
   mm4_pkg::rsp_type                                rsp_data_ff, rsp_data_in;

   always_comb begin
      shifted = '0;
      for (int j = 0; j < mm4_pkg::MAT_DIM; j++) begin
         // Arithmetic shift gives floor rounding of the exact sum.
         shifted = $signed(lane_sum[j]) >>> FRAC_BITS;
         if ((&shifted[SUM_W-1:ELEM_WIDTH-1]) || !(|shifted[SUM_W-1:ELEM_WIDTH-1])) begin
            clip[j] = shifted[ELEM_WIDTH-1:0];
         end else if (shifted[SUM_W-1]) begin
            clip[j] = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
         end else begin
            clip[j] = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
         end
         elem_out[j] = mm4_pkg::FIELD_W'($signed(clip[j]));
      end
      rsp_valid_in         = tag.valid;
      rsp_data_in.out_row  = tag.row;
      rsp_data_in.prod0    = elem_out[0];
      rsp_data_in.prod1    = elem_out[1];
      rsp_data_in.prod2    = elem_out[2];
      rsp_data_in.prod3    = elem_out[3];
      rsp_data_in.last_row = (tag.row == mm4_pkg::ROW_W'(mm4_pkg::MAT_DIM - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/matrix_multiply_4x4_unit.sv */
// Top level of the 4x4 signed fixed-point matrix multiplier.
// Depends on mm4_pkg, mm4_store, mm4_lane and mm4_merge.
`default_nettype none

// The block holds two 4x4 matrices, A and B, and computes C = A * B in signed fixed
// point with FRAC_BITS fractional bits and ELEM_WIDTH-bit elements. An item is taken
// at a clock edge where start is high and busy is low. A load item (load row of A or
// of B) writes the addressed row in that edge and leaves busy low, so loads can be
// issued every cycle. A product item raises busy; the sequencer then feeds rows 0 to
// 3 of A, one per cycle, to four lanes that each form one column of the result row
// (four multiplies, then a two-level adder tree), and a merging stage floors,
// saturates and registers the whole row. The four result items appear on rsp_data
// with rsp_valid high in consecutive cycles, each row passing the product, pair and
// sum registers of the lanes and the merge register, with last_row set on row 3. There
// is no way to stall the results: the receiver must take every item in the cycle it is
// shown. A product request keeps busy high until the last result row has left the
// merging stage, so the next item can be taken only after that. Action code 3 is
// taken and dropped, and row_index is ignored on a product request.
module matrix_multiply_4x4_unit #(
   parameter int FRAC_BITS  = mm4_pkg::DEF_FRAC_BITS,
   parameter int ELEM_WIDTH = mm4_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mm4_pkg::req_type req_data,
   output logic                  rsp_valid,
   output mm4_pkg::rsp_type      rsp_data
);

   localparam int SUM_W = 2 * ELEM_WIDTH + 2;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [mm4_pkg::ROW_W-1:0]       row_ff, row_in;
   mm4_pkg::tag_type [mm4_pkg::LANE_STAGES-1:0] tag_ff, tag_in;

   logic                            accept;
   mm4_pkg::wr_ctrl_type            wr_ctrl;
   logic [mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] wr_elems;
   logic [mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] a_row;
   logic [mm4_pkg::MAT_DIM-1:0][mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] b_mat;
   logic [mm4_pkg::MAT_DIM-1:0][mm4_pkg::MAT_DIM-1:0][ELEM_WIDTH-1:0] b_col;
   logic [mm4_pkg::MAT_DIM-1:0][SUM_W-1:0] lane_sum;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Load items write straight into the store; only the low ELEM_WIDTH bits of each
   // field are kept, read as two's complement.
   always_comb begin
      wr_ctrl.load_a = accept && (req_data.action == mm4_pkg::ACT_LOAD_A);
      wr_ctrl.load_b = accept && (req_data.action == mm4_pkg::ACT_LOAD_B);
      wr_ctrl.row    = req_data.row_index;
      wr_elems[0]    = req_data.elem0[ELEM_WIDTH-1:0];
      wr_elems[1]    = req_data.elem1[ELEM_WIDTH-1:0];
      wr_elems[2]    = req_data.elem2[ELEM_WIDTH-1:0];
      wr_elems[3]    = req_data.elem3[ELEM_WIDTH-1:0];
   end

   // Sequencer: walk the rows of A during ISSUE, then wait in DRAIN until the last
   // result row has left the merging stage.
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            if (accept && (req_data.action == mm4_pkg::ACT_PRODUCT)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            row_in = mm4_pkg::ROW_W'(row_ff + 1'b1);
            if (row_ff == mm4_pkg::ROW_W'(mm4_pkg::MAT_DIM - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_valid && rsp_data.last_row) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            row_in   = '0;
         end
      endcase
   end

   // The tag line runs beside the lanes so each result row keeps its index.
   always_comb begin
      tag_in[0].valid = (state_ff == ST_ISSUE);
      tag_in[0].row   = row_ff;
      for (int s = 1; s < mm4_pkg::LANE_STAGES; s++) begin
         tag_in[s] = tag_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         tag_ff   <= tag_in;
      end
   end

   mm4_store #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_ctrl  (wr_ctrl),
      .wr_elems (wr_elems),
      .rd_row   (row_ff),
      .a_row    (a_row),
      .b_mat    (b_mat)
   );

   // Lane j sees the current row of A and column j of B.
   for (genvar j = 0; j < mm4_pkg::MAT_DIM; j++) begin : g_lane
      for (genvar k = 0; k < mm4_pkg::MAT_DIM; k++) begin : g_col
         assign b_col[j][k] = b_mat[k][j];
      end

      mm4_lane #(
         .ELEM_WIDTH (ELEM_WIDTH)
      ) u_lane (
         .clock (clock),
         .a_row (a_row),
         .b_col (b_col[j]),
         .sum   (lane_sum[j])
      );
   end

   mm4_merge #(
      .FRAC_BITS  (FRAC_BITS),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .tag       (tag_ff[mm4_pkg::LANE_STAGES-1]),
      .lane_sum  (lane_sum),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for matrix_multiply_4x4_unit: directed and random row loads and
// product requests, with every result row predicted in the bench and compared field by field.
// Depends on mm4_pkg and the RTL of matrix_multiply_4x4_unit.
`default_nettype none

module testbench;
   import mm4_pkg::*;

   // The bench is built around the default shape of the block: Q16.16 elements in 32 bits.
   localparam int FRAC = DEF_FRAC_BITS;
   localparam int CYCLE_LIMIT = 100000;
   localparam int RANDOM_ITEMS = 360;
   localparam int DRAIN_CYCLES = 12;

   localparam logic signed [FIELD_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
   localparam logic signed [FIELD_W-1:0] ELEM_MIN = 32'h8000_0000;
   localparam logic signed [FIELD_W-1:0] ELEM_NEG_LSB = 32'hFFFF_FFFF;
   localparam logic signed [FIELD_W-1:0] Q_ONE = 32'h0001_0000;
   localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

   // One row of the directed table. All four elements of a row carry the same value, which
   // keeps the matrices uniform so that the expected product can be typed in directly.
   typedef struct {
      action_type act;
      logic [ROW_W-1:0] row;
      logic signed [FIELD_W-1:0] elem;
      bit typed;
      logic signed [FIELD_W-1:0] want;
   } plan_entry_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;

   // The bench's own copy of the two matrices, row-major.
   logic signed [FIELD_W-1:0] a_store [MAT_DIM*MAT_DIM];
   logic signed [FIELD_W-1:0] b_store [MAT_DIM*MAT_DIM];

   // Product rows still to come from the block, oldest first.
   rsp_type product_rows_due [$];
   plan_entry_type directed_plan [$];

   // A directed product request may carry a typed expectation; the monitor takes it instead
   // of the computed rows when that request is accepted.
   bit typed_pending;
   logic signed [FIELD_W-1:0] typed_value;

   int fail_count;
   int cycle_count;
   int load_count;
   int product_count;
   int ignored_count;
   int rows_checked;

   matrix_multiply_4x4_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog. Even the slowest legal run uses a small fraction of this budget.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // One element of C: the exact sum of four products, floored by the fractional bits and
   // saturated to the element width. A 66-bit sum holds four 64-bit products without loss.
   function automatic logic signed [FIELD_W-1:0] dot_element(int r, int c);
      logic signed [65:0] acc;
      logic signed [65:0] wa;
      logic signed [65:0] wb;
      logic signed [65:0] floored;
      acc = '0;
      for (int k = 0; k < MAT_DIM; k++) begin
         wa = 66'(a_store[r*MAT_DIM + k]);
         wb = 66'(b_store[k*MAT_DIM + c]);
         acc = acc + wa * wb;
      end
      floored = acc >>> FRAC;
      if (floored > SAT_HI) return ELEM_MAX;
      if (floored < SAT_LO) return ELEM_MIN;
      return floored[FIELD_W-1:0];
   endfunction

   function automatic rsp_type product_row(int r);
      rsp_type row;
      row.out_row = r[ROW_W-1:0];
      row.prod0 = dot_element(r, 0);
      row.prod1 = dot_element(r, 1);
      row.prod2 = dot_element(r, 2);
      row.prod3 = dot_element(r, 3);
      row.last_row = (r == MAT_DIM - 1);
      return row;
   endfunction

   function automatic rsp_type uniform_row(int r, logic signed [FIELD_W-1:0] value);
      rsp_type row;
      row.out_row = r[ROW_W-1:0];
      row.prod0 = value;
      row.prod1 = value;
      row.prod2 = value;
      row.prod3 = value;
      row.last_row = (r == MAT_DIM - 1);
      return row;
   endfunction

   // Applies one accepted item to the bench's matrices, or queues the four rows of C.
   task automatic absorb_item(input req_type item);
      int base;
      base = item.row_index * MAT_DIM;
      case (action_type'(item.action))
         ACT_LOAD_A: begin
            a_store[base + 0] = item.elem0;
            a_store[base + 1] = item.elem1;
            a_store[base + 2] = item.elem2;
            a_store[base + 3] = item.elem3;
            load_count++;
         end
         ACT_LOAD_B: begin
            b_store[base + 0] = item.elem0;
            b_store[base + 1] = item.elem1;
            b_store[base + 2] = item.elem2;
            b_store[base + 3] = item.elem3;
            load_count++;
         end
         ACT_PRODUCT: begin
            for (int r = 0; r < MAT_DIM; r++) begin
               if (typed_pending) product_rows_due.push_back(uniform_row(r, typed_value));
               else product_rows_due.push_back(product_row(r));
            end
            typed_pending = 1'b0;
            product_count++;
         end
         default: begin
            ignored_count++;
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
                                input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor. Both channels are sampled at the rising edge, where the inputs have been
   // stable since the falling edge and the outputs still hold their values from before it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (product_rows_due.size() == 0) begin
               $error("product row %0d arrived with no result expected", rsp_data.out_row);
               fail_count++;
            end else begin
               compare_field("out_row", FIELD_W'(product_rows_due[0].out_row),
                             FIELD_W'(rsp_data.out_row));
               compare_field("prod0", product_rows_due[0].prod0, rsp_data.prod0);
               compare_field("prod1", product_rows_due[0].prod1, rsp_data.prod1);
               compare_field("prod2", product_rows_due[0].prod2, rsp_data.prod2);
               compare_field("prod3", product_rows_due[0].prod3, rsp_data.prod3);
               compare_field("last_row", FIELD_W'(product_rows_due[0].last_row),
                             FIELD_W'(rsp_data.last_row));
               void'(product_rows_due.pop_front());
               rows_checked++;
            end
         end
         if (start && !busy) absorb_item(req_data);
      end
   end

   // Random element: mostly small Q16.16 values whose products stay in range, some full
   // 32-bit values that tend to saturate, and now and then an extreme.
   function automatic logic signed [FIELD_W-1:0] random_elem();
      logic signed [FIELD_W-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = ELEM_MAX;
               1: v = ELEM_MIN;
               2: v = '0;
               3: v = ELEM_NEG_LSB;
               default: v = Q_ONE;
            endcase
         end
         1, 2, 3: v = $urandom();
         default: begin
            v = $urandom_range(0, 32'h0020_0000);
            v = v - 32'sh0010_0000;
         end
      endcase
      return v;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) item.action = ($urandom_range(0, 1) == 0) ? ACT_LOAD_A : ACT_LOAD_B;
      else if (pick < 93) item.action = ACT_PRODUCT;
      else item.action = ACT_UNUSED;
      item.row_index = ROW_W'($urandom_range(0, MAT_DIM - 1));
      item.elem0 = random_elem();
      item.elem1 = random_elem();
      item.elem2 = random_elem();
      item.elem3 = random_elem();
      return item;
   endfunction

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void plan(action_type act, logic [ROW_W-1:0] row,
                                logic signed [FIELD_W-1:0] elem, bit typed,
                                logic signed [FIELD_W-1:0] want);
      plan_entry_type entry;
      entry.act = act;
      entry.row = row;
      entry.elem = elem;
      entry.typed = typed;
      entry.want = want;
      directed_plan.push_back(entry);
   endfunction

   // Called at a falling edge. Holds the item on the inputs until the block takes it, and
   // returns at the next falling edge with start still high.
   task automatic send_item(input req_type item);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Lowers start for a number of cycles and puts junk on the data lines meanwhile, since
   // the block must not look at them while start is low.
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) begin
            req_data <= random_item();
            @(negedge clock);
         end
      end
   endtask

   initial begin : stimulus
      req_type item;
      int gap;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      typed_pending = 1'b0;
      typed_value = '0;
      fail_count = 0;
      cycle_count = 0;
      load_count = 0;
      product_count = 0;
      ignored_count = 0;
      rows_checked = 0;
      for (int i = 0; i < MAT_DIM*MAT_DIM; i++) begin
         a_store[i] = '0;
         b_store[i] = '0;
      end

      // Directed table. The matrices are kept uniform so that each product is the same value
      // everywhere: zero after reset, positive saturation for max times max and for min
      // times min (the exact sum needs 66 bits), and negative saturation for max times min.
      plan(ACT_PRODUCT, 2'd0, '0, 1'b1, '0);
      plan(ACT_LOAD_A, 2'd0, ELEM_MAX, 1'b0, '0);
      plan(ACT_LOAD_A, 2'd1, ELEM_MAX, 1'b0, '0);
      plan(ACT_LOAD_A, 2'd2, ELEM_MAX, 1'b0, '0);
      plan(ACT_LOAD_A, 2'd3, ELEM_MAX, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd0, ELEM_MAX, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd1, ELEM_MAX, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd2, ELEM_MAX, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd3, ELEM_MAX, 1'b0, '0);
      plan(ACT_PRODUCT, 2'd0, '0, 1'b1, ELEM_MAX);
      plan(ACT_LOAD_B, 2'd0, ELEM_MIN, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd1, ELEM_MIN, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd2, ELEM_MIN, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd3, ELEM_MIN, 1'b0, '0);
      plan(ACT_PRODUCT, 2'd0, '0, 1'b1, ELEM_MIN);
      plan(ACT_LOAD_A, 2'd0, ELEM_MIN, 1'b0, '0);
      plan(ACT_LOAD_A, 2'd1, ELEM_MIN, 1'b0, '0);
      plan(ACT_LOAD_A, 2'd2, ELEM_MIN, 1'b0, '0);
      plan(ACT_LOAD_A, 2'd3, ELEM_MIN, 1'b0, '0);
      plan(ACT_PRODUCT, 2'd0, '0, 1'b1, ELEM_MAX);
      // The unused action code must leave both matrices alone, and a product request must
      // not care about its row index or elements.
      plan(ACT_UNUSED, 2'd2, Q_ONE, 1'b0, '0);
      plan(ACT_PRODUCT, 2'd3, ELEM_MIN, 1'b1, ELEM_MAX);
      // Mixed rows with a negative LSB, checked against the rows that the bench computes.
      plan(ACT_LOAD_A, 2'd1, ELEM_NEG_LSB, 1'b0, '0);
      plan(ACT_LOAD_B, 2'd2, Q_ONE, 1'b0, '0);
      plan(ACT_PRODUCT, 2'd1, '0, 1'b0, '0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[n]) begin
         item.action = directed_plan[n].act;
         item.row_index = directed_plan[n].row;
         item.elem0 = directed_plan[n].elem;
         item.elem1 = directed_plan[n].elem;
         item.elem2 = directed_plan[n].elem;
         item.elem3 = directed_plan[n].elem;
         typed_pending = directed_plan[n].typed;
         typed_value = directed_plan[n].want;
         send_item(item);
         hold_off(idle_gap());
      end

      // Random part. Every third block of 40 items runs without any idling, and halfway
      // through the sender waits until the block has delivered everything it owes.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            do @(negedge clock); while (product_rows_due.size() != 0);
            hold_off(DRAIN_CYCLES);
         end
         send_item(random_item());
         gap = ((n / 40) % 3 == 2) ? 0 : idle_gap();
         hold_off(gap);
      end

      // Drain: wait for the last product rows, then give the pipeline time to show anything
      // it should not.
      start <= 1'b0;
      while (product_rows_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d row loads, %0d product requests and %0d ignored items;",
               load_count, product_count, ignored_count);
      $display("%0d product rows were compared, %0d mismatches found.",
               rows_checked, fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
